// ----- rtl/imk_pkg.sv -----
`default_nettype none

package imk_pkg;

	typedef enum logic [1:0] {
		EL_IDLE = 2'd0,
		EL_DASH = 2'd1,
		EL_DOT  = 2'd2,
		EL_GAP  = 2'd3
	} element_t;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned TICK_W      = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_STRAIGHT_MODE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DIT_LENGTH    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DAH_LENGTH    = 2'd2;

	localparam logic [TICK_W-1:0] DIT_LENGTH_RST = 16'd60;
	localparam logic [TICK_W-1:0] DAH_LENGTH_RST = 16'd180;

endpackage

`default_nettype wire

// ----- rtl/iambic_morse_keyer_core.sv -----
// A tick item goes through the input register, then the result register holding tone and
// element state.
// Throughput: one item per cycle while the output is not stalled; the element update is one
// short pass of logic on the state registers.
// Reset: element state, queued and previous element go idle, countdown to zero, straight
// mode off, dit length 60 and dah length 180 ticks; no item held in either stage.
`default_nettype none

module iambic_morse_keyer_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output      logic                                 in_ready,
	input  wire logic                                 dot_paddle,
	input  wire logic                                 dash_paddle,
	output      logic                                 out_valid,
	input  wire logic                                 out_ready,
	output      logic                                 tone_on,
	output      logic [1:0]                           element_state,
	input  wire logic                                 cfg_we,
	input  wire logic [imk_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire logic [imk_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// configuration
	logic                             straight_q;
	logic [imk_pkg::TICK_W-1:0]       dit_len_q;
	logic [imk_pkg::TICK_W-1:0]       dah_len_q;

	// input stage
	logic valid_s1;
	logic dot_s1;
	logic dash_s1;

	// keyer state
	imk_pkg::element_t                cur_q, que_q, prev_q;
	logic [imk_pkg::TICK_W-1:0]       ticks_q;

	// result register
	logic                             out_valid_q;
	logic                             tone_q;
	imk_pkg::element_t                state_out_q;

	logic                             adv;
	logic                             step;
	logic [imk_pkg::TICK_W-1:0]       ticks_dec;
	logic                             expired;
	imk_pkg::element_t                cur_d, que_d, prev_d;
	logic [imk_pkg::TICK_W-1:0]       ticks_d;
	logic                             tone_d;

	assign adv      = !out_valid_q || out_ready;
	assign step     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	assign out_valid     = out_valid_q;
	assign tone_on       = tone_q;
	assign element_state = 2'(state_out_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			straight_q <= 1'b0;
			dit_len_q  <= imk_pkg::DIT_LENGTH_RST;
			dah_len_q  <= imk_pkg::DAH_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				imk_pkg::REG_STRAIGHT_MODE: straight_q <= cfg_data[0];
				imk_pkg::REG_DIT_LENGTH:    dit_len_q  <= cfg_data;
				imk_pkg::REG_DAH_LENGTH:    dah_len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dot_s1  <= dot_paddle;
			dash_s1 <= dash_paddle;
		end
	end

	// saturating countdown, decremented at the start of every tick
	assign ticks_dec = (ticks_q != '0) ? ticks_q - 1'b1 : ticks_q;
	assign expired   = (ticks_dec == '0);

	always_comb begin
		cur_d   = cur_q;
		que_d   = que_q;
		prev_d  = prev_q;
		ticks_d = ticks_dec;
		tone_d  = 1'b0;
		if (straight_q) begin
			tone_d = dot_s1 || dash_s1;
		end else begin
			case (cur_q)
				imk_pkg::EL_DASH: begin
					tone_d = 1'b1;
					if (dot_s1 && que_q == imk_pkg::EL_IDLE) begin
						que_d = imk_pkg::EL_DOT;
					end
					if (expired) begin
						prev_d  = imk_pkg::EL_DASH;
						cur_d   = imk_pkg::EL_GAP;
						ticks_d = dit_len_q;
					end
				end
				imk_pkg::EL_DOT: begin
					tone_d = 1'b1;
					if (dash_s1 && que_q == imk_pkg::EL_IDLE) begin
						que_d = imk_pkg::EL_DASH;
					end
					if (expired) begin
						prev_d  = imk_pkg::EL_DOT;
						cur_d   = imk_pkg::EL_GAP;
						ticks_d = dit_len_q;
					end
				end
				imk_pkg::EL_IDLE: begin
					if (dot_s1 && !dash_s1) begin
						prev_d  = imk_pkg::EL_IDLE;
						cur_d   = imk_pkg::EL_DOT;
						ticks_d = dit_len_q;
					end else if (!dot_s1 && dash_s1) begin
						prev_d  = imk_pkg::EL_IDLE;
						cur_d   = imk_pkg::EL_DASH;
						ticks_d = dah_len_q;
					end else if (dot_s1 && dash_s1 && que_q == imk_pkg::EL_IDLE) begin
						// squeeze from idle: dot first, timed with the dash length
						prev_d  = imk_pkg::EL_IDLE;
						cur_d   = imk_pkg::EL_DOT;
						que_d   = imk_pkg::EL_DASH;
						ticks_d = dah_len_q;
					end
				end
				default: begin
					// gap: play the queued element when it runs out
					if (expired) begin
						cur_d = que_q;
						if (que_q == imk_pkg::EL_DOT) begin
							ticks_d = dit_len_q;
						end else if (que_q == imk_pkg::EL_DASH) begin
							ticks_d = dah_len_q;
						end
						prev_d = imk_pkg::EL_GAP;
						que_d  = imk_pkg::EL_IDLE;
					end
					if (prev_d == imk_pkg::EL_DOT && dash_s1 && que_d == imk_pkg::EL_IDLE) begin
						que_d = imk_pkg::EL_DASH;
					end else if (prev_d == imk_pkg::EL_DASH && dot_s1 &&
							que_d == imk_pkg::EL_IDLE) begin
						que_d = imk_pkg::EL_DOT;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= imk_pkg::EL_IDLE;
			que_q       <= imk_pkg::EL_IDLE;
			prev_q      <= imk_pkg::EL_IDLE;
			ticks_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				cur_q   <= cur_d;
				que_q   <= que_d;
				prev_q  <= prev_d;
				ticks_q <= ticks_d;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			tone_q      <= tone_d;
			state_out_q <= cur_d;
		end
	end

	// idle is only reached once the countdown has run out
	a_idle_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q == imk_pkg::EL_IDLE |-> ticks_q == '0)
		else $error("countdown running while idle");

	a_queue_never_gap: assert property (@(posedge clk) disable iff (!arst_n)
		que_q != imk_pkg::EL_GAP)
		else $error("gap queued as an element");

	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid && element_state == 2'(cur_q))
		else $error("result state differs from keyer state");

	a_held_item_stays: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(cur_q) && $stable(ticks_q))
		else $error("stalled item lost or state moved");

endmodule

`default_nettype wire
